### rtl/pdmr_pkg.sv
// ----------------------------------------------------------------------------
// pdmr_pkg
// shared types and constants of the pwm duty meter with rotor indicator
// ----------------------------------------------------------------------------
package pdmr_pkg;

	localparam int ROTOR_POSITIONS_DEF = 12;
	localparam int DUTY_SCALE          = 100;
	localparam int ADVANCE_AT_FULL     = 5;
	localparam int QUO_W               = 7;
	localparam int SUM_W               = 32;
	localparam int NUM_W               = SUM_W + QUO_W;

	typedef enum logic {
		ACT_LEVEL = 1'b0,
		ACT_FRAME = 1'b1
	} pdmr_action_t;

	typedef struct packed {
		logic        action;
		logic [63:0] timestamp_ns;
		logic        pin_level;
	} pdmr_in_t;

	typedef struct packed {
		logic [6:0] duty_percent;
		logic [3:0] rotor_position;
		logic       spinning;
	} pdmr_out_t;

endpackage

### rtl/pwm_duty_meter_rotor.sv
// level change: no transaction on the result side
// frame tick: result valid after prepare, 7 divide steps and load (load waits while the output stalls)
// a new frame tick is taken only once the last one is through the serial restoring divide step
// the input side stalls while a frame tick is in the divider or its result waits
// reset (arst_n low) clears sums, timestamp and rotor, sets the line level high
// ----------------------------------------------------------------------------
// pwm_duty_meter_rotor
// duty cycle meter over frame windows with a serial divider and rotor counter
// ----------------------------------------------------------------------------
module pwm_duty_meter_rotor #(
	parameter int ROTOR_POSITIONS = pdmr_pkg::ROTOR_POSITIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pdmr_pkg::pdmr_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output pdmr_pkg::pdmr_out_t result
);
	import pdmr_pkg::*;

	localparam int WRAP_W     = 5;
	localparam int WRAP_STEPS = (ADVANCE_AT_FULL + ROTOR_POSITIONS - 1) / ROTOR_POSITIONS;
	localparam logic [WRAP_W-1:0] POS = WRAP_W'(ROTOR_POSITIONS);
	localparam int CNT_W      = $clog2(QUO_W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [63:0]        last_q;
	logic [SUM_W-1:0]   low_q;
	logic [SUM_W-1:0]   high_q;
	logic               level_q;
	logic [3:0]         rotor_q;
	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   div_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zero_q;

	logic               item_acc;
	logic [SUM_W-1:0]   delta;
	logic [SUM_W:0]     acc_sum;
	logic [SUM_W-1:0]   acc_sat;
	logic [SUM_W:0]     total;
	logic               ge;
	logic [QUO_W-1:0]   duty;
	logic               out_free;

	function automatic logic [2:0] advance(input logic [QUO_W-1:0] d);
		logic [2:0] a;
		if (d >= 7'd100)     a = 3'd5;
		else if (d >= 7'd80) a = 3'd4;
		else if (d >= 7'd60) a = 3'd3;
		else if (d >= 7'd40) a = 3'd2;
		else if (d >= 7'd20) a = 3'd1;
		else                 a = 3'd0;
		return a;
	endfunction

	function automatic logic [3:0] wrap(input logic [WRAP_W-1:0] s);
		logic [WRAP_W-1:0] v;
		v = s;
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (v >= POS) v = v - POS;
		end
		return v[3:0];
	endfunction

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign delta      = item.timestamp_ns[SUM_W-1:0] - last_q[SUM_W-1:0];
	assign acc_sum    = {1'b0, (level_q ? high_q : low_q)} + {1'b0, delta};
	assign acc_sat    = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
	assign total      = {1'b0, low_q} + {1'b0, high_q};
	assign ge         = (rem_q >= div_q);
	assign duty       = zero_q ? '0 : quo_q;
	assign out_free   = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_q       <= '0;
			low_q        <= '0;
			high_q       <= '0;
			level_q      <= 1'b1;
			rotor_q      <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_DONE) result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						last_q <= item.timestamp_ns;
						if (level_q) high_q <= acc_sat;
						else         low_q  <= acc_sat;
						if (item.action == ACT_FRAME) state_q <= ST_PREP;
						else                          level_q <= item.pin_level;
					end
				end
				ST_PREP: begin
					low_q   <= '0;
					high_q  <= '0;
					cnt_q   <= CNT_W'(QUO_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rotor_q      <= wrap(WRAP_W'(rotor_q) + WRAP_W'(advance(duty)));
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			rem_q  <= NUM_W'(low_q) * 7'(DUTY_SCALE);
			div_q  <= {total, {(QUO_W-1){1'b0}}};
			zero_q <= (total == '0);
			quo_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (ge) rem_q <= rem_q - div_q;
			div_q <= div_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (state_q == ST_DONE && out_free) begin
			result.duty_percent   <= duty;
			result.rotor_position <= wrap(WRAP_W'(rotor_q) + WRAP_W'(advance(duty)));
			result.spinning       <= (duty != '0);
		end
	end

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.duty_percent <= 7'(DUTY_SCALE))
		else $error("duty out of range");

	a_rotor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 5'(result.rotor_position) < POS)
		else $error("rotor position out of range");

	a_spin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.spinning == (result.duty_percent != '0))
		else $error("spinning flag mismatch");

	a_level_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.action == ACT_LEVEL && !result_valid) |=> !result_valid)
		else $error("level change produced a transaction");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (low_q == '0 && high_q == '0))
		else $error("sums not cleared after frame tick");

endmodule
